### hdl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int CFG_W = 10;
  localparam int CTR_W = 11;
  localparam int CRD_W = 13;

  localparam logic [CFG_W-1:0] SEMI_X_RST = 10'd90;
  localparam logic [CFG_W-1:0] SEMI_Y_RST = 10'd75;

  localparam logic REG_SEMI_X = 1'b0;
  localparam logic REG_SEMI_Y = 1'b1;

  localparam logic OPC_START = 1'b0;
  localparam logic OPC_STEP  = 1'b1;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
  localparam logic [OP_W-1:0] OP_SQ_A    = 4'd2;
  localparam logic [OP_W-1:0] OP_SQ_B    = 4'd3;
  localparam logic [OP_W-1:0] OP_ST_MUL  = 4'd4;
  localparam logic [OP_W-1:0] OP_ST_INIT = 4'd5;
  localparam logic [OP_W-1:0] OP_ZERO    = 4'd6;
  localparam logic [OP_W-1:0] OP_ADV1    = 4'd7;
  localparam logic [OP_W-1:0] OP_ADV2    = 4'd8;
  localparam logic [OP_W-1:0] OP_R2_1    = 4'd9;
  localparam logic [OP_W-1:0] OP_R2_2    = 4'd10;
  localparam logic [OP_W-1:0] OP_R2_3    = 4'd11;
  localparam logic [OP_W-1:0] OP_R2_4    = 4'd12;
  localparam logic [OP_W-1:0] OP_R2_5    = 4'd13;
  localparam logic [OP_W-1:0] OP_R2_6    = 4'd14;
  localparam logic [OP_W-1:0] OP_EMIT    = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            region2;
    logic            last;
  } cmd_t;

  typedef struct packed {
    logic item_start;
    logic slope_done;
    logic y_neg;
    logic out_free;
  } status_t;

endpackage

### hdl/mer_ctrl.sv
// Controller state machine of the midpoint ellipse rasterizer.
module mer_ctrl import mer_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    cfg_write,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQA  = 4'd1;
  localparam logic [3:0] S_SQB  = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_INIT = 4'd4;
  localparam logic [3:0] S_ADV1 = 4'd5;
  localparam logic [3:0] S_ADV2 = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_R2_1 = 4'd8;
  localparam logic [3:0] S_R2_2 = 4'd9;
  localparam logic [3:0] S_R2_3 = 4'd10;
  localparam logic [3:0] S_R2_4 = 4'd11;
  localparam logic [3:0] S_R2_5 = 4'd12;
  localparam logic [3:0] S_R2_6 = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_R1   = 2'd1;
  localparam logic [1:0] PH_R2   = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic       dirty, dirty_next;
  logic       post_start, post_start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_IDLE;
      dirty      <= 1'b1;
      post_start <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      dirty      <= dirty_next;
      post_start <= post_start_next;
    end
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    dirty_next      = dirty;
    post_start_next = post_start;
    in_ready        = (state == S_IDLE);
    cmd.op          = OP_NONE;
    cmd.region2     = (phase == PH_R2);
    cmd.last        = (phase == PH_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = dirty ? S_SQA : S_DEC;
        end
      end
      S_SQA: begin
        cmd.op     = OP_SQ_A;
        state_next = S_SQB;
      end
      S_SQB: begin
        cmd.op     = OP_SQ_B;
        dirty_next = 1'b0;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (status.item_start) begin
          cmd.op     = OP_ST_MUL;
          state_next = S_INIT;
        end else if (phase == PH_IDLE) begin
          cmd.op     = OP_ZERO;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_ADV1;
          state_next = S_ADV2;
        end
      end
      S_INIT: begin
        cmd.op          = OP_ST_INIT;
        phase_next      = PH_R1;
        post_start_next = 1'b1;
        state_next      = S_CHK;
      end
      S_ADV1: begin
        cmd.op     = OP_ADV1;
        state_next = S_ADV2;
      end
      S_ADV2: begin
        cmd.op     = OP_ADV2;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (phase == PH_R1 && status.slope_done) begin
          state_next = S_R2_1;
        end else begin
          if (phase == PH_R2 && status.y_neg) begin
            phase_next = PH_IDLE;
          end
          if (post_start) begin
            post_start_next = 1'b0;
            state_next      = S_ADV1;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_R2_1: begin
        cmd.op     = OP_R2_1;
        state_next = S_R2_2;
      end
      S_R2_2: begin
        cmd.op     = OP_R2_2;
        state_next = S_R2_3;
      end
      S_R2_3: begin
        cmd.op     = OP_R2_3;
        state_next = S_R2_4;
      end
      S_R2_4: begin
        cmd.op     = OP_R2_4;
        state_next = S_R2_5;
      end
      S_R2_5: begin
        cmd.op     = OP_R2_5;
        state_next = S_R2_6;
      end
      S_R2_6: begin
        cmd.op     = OP_R2_6;
        phase_next = PH_R2;
        state_next = S_CHK;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_write) begin
      dirty_next = 1'b1;
    end
  end

endmodule

### hdl/mer_dpath.sv
// Datapath of the midpoint ellipse rasterizer: axis registers, shared multiplier and decision terms.
module mer_dpath import mer_pkg::*; #(
  parameter int AXIS_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    opcode,
  input  logic [CTR_W-1:0]        center_x,
  input  logic [CTR_W-1:0]        center_y,
  input  cmd_t                    cmd,
  output status_t                 status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    point_valid,
  output logic signed [CRD_W-1:0] right_x,
  output logic signed [CRD_W-1:0] left_x,
  output logic signed [CRD_W-1:0] upper_y,
  output logic signed [CRD_W-1:0] lower_y,
  output logic                    last_point
);

  localparam int AB  = AXIS_BITS;
  localparam int OW  = AB + 2;
  localparam int SW  = 3 * AB + 4;
  localparam int DW  = 4 * AB + 8;
  localparam int MOW = 2 * AB + 3;
  localparam int PW  = 2 * MOW;
  localparam int SQW = 2 * AB;
  localparam int EW  = (OW > CRD_W) ? OW : CRD_W;

  logic [AB-1:0]           semi_x, semi_y;
  logic [SQW-1:0]          a2, b2;
  logic signed [PW-1:0]    prod;
  logic signed [OW-1:0]    off_x, off_y;
  logic signed [SW-1:0]    slope_x, slope_y;
  logic signed [DW-1:0]    dec;
  logic [CTR_W-1:0]        lat_cx, lat_cy;
  logic                    item_start;
  logic                    res_valid;
  logic [CRD_W-1:0]        res_rx, res_lx, res_uy, res_ly;

  logic signed [MOW-1:0]   a_m, b_m, a2_m, b2_m, tx_m, ty_m, prod_lo;
  logic signed [MOW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]    mul_p;
  logic signed [OW:0]      tx_w, ty_w;
  logic signed [DW-1:0]    a2_d, b2_d, sx_d, sy_d, prod_d, adv_term;
  logic signed [SW-1:0]    a2_s2, b2_s2;
  logic                    d_neg, d_pos, x_inc, y_dec;
  logic [EW-1:0]           cx_e, cy_e, x_e, y_e;
  logic [EW-1:0]           rx_sum, lx_sum, uy_sum, ly_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_x <= AB'(SEMI_X_RST);
      semi_y <= AB'(SEMI_Y_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEMI_X: semi_x <= AB'(cfg_data);
        REG_SEMI_Y: semi_y <= AB'(cfg_data);
        default: ;
      endcase
    end
  end

  assign a_m     = MOW'(semi_x);
  assign b_m     = MOW'(semi_y);
  assign a2_m    = MOW'(a2);
  assign b2_m    = MOW'(b2);
  assign tx_w    = {off_x, 1'b1};
  assign ty_w    = (OW + 1)'(off_y) - (OW + 1)'(1);
  assign tx_m    = MOW'(tx_w);
  assign ty_m    = MOW'(ty_w);
  assign prod_lo = prod[MOW-1:0];

  always_comb begin
    case (cmd.op)
      OP_SQ_A: begin
        mul_a = a_m;
        mul_b = a_m;
      end
      OP_SQ_B: begin
        mul_a = b_m;
        mul_b = b_m;
      end
      OP_ST_MUL: begin
        mul_a = a2_m;
        mul_b = b_m;
      end
      OP_R2_1: begin
        mul_a = tx_m;
        mul_b = tx_m;
      end
      OP_R2_2: begin
        mul_a = b2_m;
        mul_b = prod_lo;
      end
      OP_R2_3: begin
        mul_a = ty_m;
        mul_b = ty_m;
      end
      OP_R2_4: begin
        mul_a = a2_m;
        mul_b = prod_lo;
      end
      OP_R2_5: begin
        mul_a = a2_m;
        mul_b = b2_m;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign a2_d   = DW'(a2);
  assign b2_d   = DW'(b2);
  assign sx_d   = DW'(slope_x);
  assign sy_d   = DW'(slope_y);
  assign prod_d = DW'(prod);
  assign a2_s2  = SW'(a2) << 1;
  assign b2_s2  = SW'(b2) << 1;

  assign d_neg = dec[DW-1];
  assign d_pos = !dec[DW-1] && (|dec);
  assign x_inc = !cmd.region2 || !d_pos;
  assign y_dec = cmd.region2 || !d_neg;

  // Region 1 adds the x slope always and subtracts the y slope on a diagonal move;
  // region 2 does the reverse.
  assign adv_term = (x_inc ? sx_d : DW'(0)) - (y_dec ? sy_d : DW'(0))
                  + (cmd.region2 ? a2_d : b2_d);

  assign cx_e   = EW'(lat_cx);
  assign cy_e   = EW'(lat_cy);
  assign x_e    = EW'(off_x);
  assign y_e    = EW'(off_y);
  assign rx_sum = cx_e + x_e;
  assign lx_sum = cx_e - x_e;
  assign uy_sum = cy_e + y_e;
  assign ly_sum = cy_e - y_e;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        item_start <= (opcode == OPC_START);
        if (opcode == OPC_START) begin
          lat_cx <= center_x;
          lat_cy <= center_y;
        end
      end
      OP_SQ_A: a2 <= mul_p[SQW-1:0];
      OP_SQ_B: b2 <= mul_p[SQW-1:0];
      OP_ST_MUL: prod <= mul_p;
      OP_ST_INIT: begin
        off_x   <= '0;
        off_y   <= OW'(semi_y);
        slope_x <= '0;
        slope_y <= SW'(prod) << 1;
        dec     <= (b2_d << 2) + a2_d - (prod_d << 2);
      end
      OP_ZERO: begin
        res_valid <= 1'b0;
        res_rx    <= '0;
        res_lx    <= '0;
        res_uy    <= '0;
        res_ly    <= '0;
      end
      OP_ADV1: begin
        res_valid <= 1'b1;
        res_rx    <= rx_sum[CRD_W-1:0];
        res_lx    <= lx_sum[CRD_W-1:0];
        res_uy    <= uy_sum[CRD_W-1:0];
        res_ly    <= ly_sum[CRD_W-1:0];
        if (x_inc) begin
          off_x   <= off_x + OW'(1);
          slope_x <= slope_x + b2_s2;
        end
        if (y_dec) begin
          off_y   <= off_y - OW'(1);
          slope_y <= slope_y - a2_s2;
        end
      end
      OP_ADV2: dec <= dec + (adv_term << 2);
      OP_R2_1: prod <= mul_p;
      OP_R2_2: prod <= mul_p;
      OP_R2_3: begin
        dec  <= prod_d;
        prod <= mul_p;
      end
      OP_R2_4: prod <= mul_p;
      OP_R2_5: begin
        dec  <= dec + (prod_d << 2);
        prod <= mul_p;
      end
      OP_R2_6: dec <= dec - (prod_d << 2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      point_valid <= res_valid;
      right_x     <= res_rx;
      left_x      <= res_lx;
      upper_y     <= res_uy;
      lower_y     <= res_ly;
      last_point  <= res_valid && cmd.last;
    end
  end

  assign status.item_start = item_start;
  assign status.slope_done = (slope_x >= slope_y);
  assign status.y_neg      = off_y[OW-1];
  assign status.out_free   = !out_valid || out_ready;

endmodule

### hdl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: controller, datapath and checks.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    opcode, center_x, center_y
//   out      out_valid / out_ready  point_valid, right_x, left_x, upper_y, lower_y, last_point
//   cfg      cfg_write              cfg_index, cfg_data
//
// One item is worked at a time. A start initialises the decision terms, a step advances
// one point or, while idle, returns an empty result, and the region change recomputes the
// terms through the shared multiplier. The first item after reset or after a register
// write first squares the axes.
// Reset is synchronous and leaves the block idle with the reset axes.
// A stalled output holds the finished result while the block waits to load the next one.
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int AXIS_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic [CTR_W-1:0]        center_x,
  input  logic [CTR_W-1:0]        center_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    point_valid,
  output logic signed [CRD_W-1:0] right_x,
  output logic signed [CRD_W-1:0] left_x,
  output logic signed [CRD_W-1:0] upper_y,
  output logic signed [CRD_W-1:0] lower_y,
  output logic                    last_point
);

  cmd_t    cmd;
  status_t status;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_write(cfg_write),
    .status   (status),
    .cmd      (cmd)
  );

  mer_dpath #(
    .AXIS_BITS(AXIS_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .center_x   (center_x),
    .center_y   (center_y),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_valid(point_valid),
    .right_x    (right_x),
    .left_x     (left_x),
    .upper_y    (upper_y),
    .lower_y    (lower_y),
    .last_point (last_point)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_point |-> point_valid)
    else $error("last point flagged on an empty result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> right_x == 0 && left_x == 0 && upper_y == 0 && lower_y == 0)
    else $error("empty result carries coordinates");

endmodule
